### design/i2cms_pkg.sv
package i2cms_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int PROD_W = (TIMER_WIDTH > 19) ? TIMER_WIDTH : 19;
  localparam logic [PROD_W:0] TIMER_MAX = ({{PROD_W{1'b0}}, 1'b1} << TIMER_WIDTH) - 1'b1;

  localparam logic [15:0] TPU_RST = 16'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;
  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [2:0] PH_POLL = 3'd3;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_WAIT  = 3'd4,
    KIND_READ  = 3'd5
  } kind_t;

  typedef enum logic [5:0] {
    OP_IDLE  = 6'b000001,
    OP_START = 6'b000010,
    OP_STOP  = 6'b000100,
    OP_WRITE = 6'b001000,
    OP_WAIT  = 6'b010000,
    OP_READ  = 6'b100000
  } op_t;

  typedef struct packed {
    logic [15:0] tpu;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } result_t;

  typedef struct packed {
    op_t                    op;
    logic [2:0]             phase;
    logic [TIMER_WIDTH-1:0] delay;
    logic [3:0]             bit_idx;
    logic [7:0]             shift;
    logic [15:0]            wait_cnt;
    logic                   scl;
    logic                   sda;
    logic                   drive;
    logic                   ack_choice;
    logic [7:0]             rx_hold;
    logic                   fail;
    logic                   done;
  } seq_state_t;

  localparam seq_state_t STATE_RST = '{
    op: OP_IDLE, phase: 3'd0, delay: '0, bit_idx: 4'd0, shift: 8'd0,
    wait_cnt: 16'd0, scl: 1'b1, sda: 1'b1, drive: 1'b1, ack_choice: 1'b0,
    rx_hold: 8'd0, fail: 1'b0, done: 1'b0
  };

  // Loads the segment delay: units of tpu ticks, saturated to the timer width.
  function automatic seq_state_t wait_units(seq_state_t s, logic [15:0] tpu,
                                            logic [2:0] units, logic [2:0] nxt);
    logic [15:0]       t;
    logic [PROD_W-1:0] prod;
    seq_state_t        r;
    r = s;
    t = (tpu == 16'd0) ? 16'd1 : tpu;
    prod = PROD_W'(t) * PROD_W'(units);
    if ({1'b0, prod} > TIMER_MAX) begin
      r.delay = TIMER_MAX[TIMER_WIDTH-1:0];
    end else begin
      r.delay = prod[TIMER_WIDTH-1:0];
    end
    r.phase = nxt;
    return r;
  endfunction

  function automatic seq_state_t finish(seq_state_t s);
    seq_state_t r;
    r = s;
    r.op = OP_IDLE;
    r.phase = 3'd0;
    r.delay = '0;
    r.done = 1'b1;
    return r;
  endfunction

  // One SDA sample of the acknowledge wait. A timeout turns the command into a stop.
  function automatic seq_state_t poll(seq_state_t s, logic sda, cfg_t cfg);
    seq_state_t r;
    r = s;
    if (!sda) begin
      r.scl = 1'b0;
      r = finish(r);
    end else if (r.wait_cnt >= cfg.ack_timeout) begin
      r.fail = 1'b1;
      r.op = OP_STOP;
      r.drive = 1'b1;
      r.scl = 1'b0;
      r.sda = 1'b0;
      r = wait_units(r, cfg.tpu, 3'd4, 3'd1);
    end else begin
      r.wait_cnt = r.wait_cnt + 16'd1;
    end
    return r;
  endfunction

  // Actions at the start of the current phase of the running command.
  function automatic seq_state_t segment(seq_state_t s, logic sda, cfg_t cfg);
    seq_state_t r;
    r = s;
    unique case (r.op)
      OP_START: begin
        if (r.phase == 3'd0) begin
          r.drive = 1'b1; r.sda = 1'b1; r.scl = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd4, 3'd1);
        end else if (r.phase == 3'd1) begin
          r.sda = 1'b0;
          r = wait_units(r, cfg.tpu, 3'd4, 3'd2);
        end else begin
          r.scl = 1'b0;
          r = finish(r);
        end
      end
      OP_STOP: begin
        if (r.phase == 3'd0) begin
          r.drive = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
          r = wait_units(r, cfg.tpu, 3'd4, 3'd1);
        end else if (r.phase == 3'd1) begin
          r.scl = 1'b1; r.sda = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd4, 3'd2);
        end else begin
          r = finish(r);
        end
      end
      OP_WRITE: begin
        if (r.phase == 3'd0) begin
          r.scl = 1'b0; r.drive = 1'b1; r.bit_idx = 4'd0;
          r = wait_units(r, cfg.tpu, 3'd1, 3'd1);
        end else if (r.phase == 3'd1) begin
          r.sda = r.shift[3'(LAST_BIT - r.bit_idx[2:0])];
          r = wait_units(r, cfg.tpu, 3'd2, 3'd2);
        end else if (r.phase == 3'd2) begin
          r.scl = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd2, 3'd3);
        end else if (r.phase == 3'd3) begin
          r.scl = 1'b0;
          r = wait_units(r, cfg.tpu, 3'd1, 3'd4);
        end else begin
          r.bit_idx = r.bit_idx + 4'd1;
          if (r.bit_idx < BITS_PER_BYTE) begin
            r = wait_units(r, cfg.tpu, 3'd1, 3'd1);
          end else begin
            r = finish(r);
          end
        end
      end
      OP_WAIT: begin
        if (r.phase == 3'd0) begin
          r.scl = 1'b0;
          r = wait_units(r, cfg.tpu, 3'd1, 3'd1);
        end else if (r.phase == 3'd1) begin
          r.drive = 1'b1; r.sda = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd1, 3'd2);
        end else if (r.phase == 3'd2) begin
          r.drive = 1'b0; r.scl = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd1, PH_POLL);
        end else begin
          r = poll(r, sda, cfg);
        end
      end
      OP_READ: begin
        if (r.phase == 3'd0) begin
          r.scl = 1'b0; r.drive = 1'b0; r.bit_idx = 4'd0; r.shift = 8'd0;
          r = wait_units(r, cfg.tpu, 3'd2, 3'd1);
        end else if (r.phase == 3'd1) begin
          r.scl = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd3, 3'd2);
        end else if (r.phase == 3'd2) begin
          r.shift = {r.shift[6:0], sda};
          r = wait_units(r, cfg.tpu, 3'd2, 3'd3);
        end else if (r.phase == 3'd3) begin
          r.scl = 1'b0;
          r.bit_idx = r.bit_idx + 4'd1;
          if (r.bit_idx < BITS_PER_BYTE) begin
            r = wait_units(r, cfg.tpu, 3'd2, 3'd1);
          end else begin
            r.rx_hold = r.shift;
            r.drive = 1'b1;
            r.sda = !r.ack_choice;
            r = wait_units(r, cfg.tpu, 3'd2, 3'd4);
          end
        end else if (r.phase == 3'd4) begin
          r.scl = 1'b1;
          r = wait_units(r, cfg.tpu, 3'd2, 3'd5);
        end else begin
          r.scl = 1'b0;
          r = finish(r);
        end
      end
      default: begin
        r = finish(r);
      end
    endcase
    return r;
  endfunction

endpackage

### design/i2cms_in_if.sv
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source(output valid, kind, tx_byte, send_ack, sda_in, input ready);
  modport sink(input valid, kind, tx_byte, send_ack, sda_in, output ready);
endinterface

### design/i2cms_out_if.sv
interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source(output valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
                 ack_failed, input ready);
  modport sink(input valid, scl, sda_out, sda_drive, busy_res, done_res, rx_byte,
               ack_failed, output ready);
endinterface

### design/i2cms_engine.sv
module i2cms_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cms_pkg::cfg_t     cfg,
  i2cms_in_if.sink            in_ch,
  i2cms_out_if.source         out_ch
);

  logic                   s1_valid_r;
  i2cms_pkg::item_t       s1_item_r;
  i2cms_pkg::seq_state_t  state_r;
  i2cms_pkg::seq_state_t  state_nxt;
  logic                   out_valid_r;
  i2cms_pkg::result_t     out_r;
  i2cms_pkg::result_t     out_nxt;
  logic                   advance;

  // The result stage moves whenever it is empty or its word is being taken.
  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  always_comb begin
    state_nxt = state_r;
    state_nxt.done = 1'b0;
    case (s1_item_r.kind) inside
      i2cms_pkg::KIND_TICK: begin
        if (state_r.op != i2cms_pkg::OP_IDLE) begin
          if (state_r.op == i2cms_pkg::OP_WAIT && state_r.phase == i2cms_pkg::PH_POLL) begin
            state_nxt = i2cms_pkg::poll(state_nxt, s1_item_r.sda_in, cfg);
          end else begin
            if (state_nxt.delay != '0) begin
              state_nxt.delay = state_nxt.delay - i2cms_pkg::TIMER_WIDTH'(1);
            end
            if (state_nxt.delay == '0) begin
              state_nxt = i2cms_pkg::segment(state_nxt, s1_item_r.sda_in, cfg);
              // Entering the poll phase samples SDA on the same tick.
              if (state_nxt.op == i2cms_pkg::OP_WAIT &&
                  state_nxt.phase == i2cms_pkg::PH_POLL) begin
                state_nxt = i2cms_pkg::poll(state_nxt, s1_item_r.sda_in, cfg);
              end
            end
          end
        end
      end
      i2cms_pkg::KIND_START, i2cms_pkg::KIND_STOP, i2cms_pkg::KIND_WRITE,
      i2cms_pkg::KIND_WAIT, i2cms_pkg::KIND_READ: begin
        if (state_r.op == i2cms_pkg::OP_IDLE) begin
          state_nxt.phase = 3'd0;
          unique case (s1_item_r.kind)
            i2cms_pkg::KIND_START: state_nxt.op = i2cms_pkg::OP_START;
            i2cms_pkg::KIND_STOP:  state_nxt.op = i2cms_pkg::OP_STOP;
            i2cms_pkg::KIND_WRITE: begin
              state_nxt.op = i2cms_pkg::OP_WRITE;
              state_nxt.shift = s1_item_r.tx_byte;
            end
            i2cms_pkg::KIND_WAIT: begin
              state_nxt.op = i2cms_pkg::OP_WAIT;
              state_nxt.fail = 1'b0;
              state_nxt.wait_cnt = 16'd0;
            end
            default: begin
              state_nxt.op = i2cms_pkg::OP_READ;
              state_nxt.ack_choice = s1_item_r.send_ack;
            end
          endcase
          state_nxt = i2cms_pkg::segment(state_nxt, s1_item_r.sda_in, cfg);
        end
      end
      default: begin
        state_nxt.done = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_nxt.scl        = state_nxt.scl;
    out_nxt.sda_out    = state_nxt.drive & state_nxt.sda;
    out_nxt.sda_drive  = state_nxt.drive;
    out_nxt.busy_res   = (state_nxt.op != i2cms_pkg::OP_IDLE);
    out_nxt.done_res   = state_nxt.done;
    out_nxt.rx_byte    = state_nxt.rx_hold;
    out_nxt.ack_failed = state_nxt.fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= i2cms_pkg::STATE_RST;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_item_r.kind     <= in_ch.kind;
      s1_item_r.tx_byte  <= in_ch.tx_byte;
      s1_item_r.send_ack <= in_ch.send_ack;
      s1_item_r.sda_in   <= in_ch.sda_in;
    end
    if (advance && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl        = out_r.scl;
  assign out_ch.sda_out    = out_r.sda_out;
  assign out_ch.sda_drive  = out_r.sda_drive;
  assign out_ch.busy_res   = out_r.busy_res;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.rx_byte    = out_r.rx_byte;
  assign out_ch.ack_failed = out_r.ack_failed;

endmodule

### design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer. Each input word is either a tick, which advances the bus
// timing, or a command (start, stop, write byte, wait for acknowledge, read byte), which
// is taken only while no command runs; a command that arrives while busy, or an unused
// kind code, is dropped without advancing time. Every input word produces exactly one
// result word with the SCL/SDA levels, busy, a done pulse, the last received byte and
// the acknowledge failure flag. One delay unit is ticks_per_unit ticks (zero counts as
// one); a wait-ack that sees SDA high on more than ack_timeout polls issues a stop and
// sets ack_failed. It takes one word per clock cycle unless the result side stalls:
// each word passes an input register, then one pass of state update into the state and
// result registers, with backpressure on the result side stalling both stages.
// Configuration registers sit at byte address 0 (ticks_per_unit) and 4 (ack_timeout).
// A ticks_per_unit write applies from the next segment delay loaded, ack_timeout from the
// next poll; a write should only be made while no word is in flight inside the block.
module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  i2cms_in_if.sink    in_ch,
  i2cms_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cms_pkg::cfg_t cfg_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tpu         <= i2cms_pkg::TPU_RST;
      cfg_r.ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_r.ack_timeout <= pwdata[15:0];
      end else begin
        cfg_r.tpu <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {16'd0, cfg_r.ack_timeout} : {16'd0, cfg_r.tpu};

  i2cms_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
